// ===== hdl/fgkr_pkg.sv =====
// Package for the face grouping block: sizes, item types and memory record types.
`timescale 1ns / 1ps
`default_nettype none

package fgkr_pkg;

	localparam int MAX_GROUPS = 64;
	localparam int MAX_IDS    = 4;
	localparam int ID_FIELDS  = 4;
	localparam int ID_W       = 16;
	localparam int KEY_W      = ID_FIELDS * ID_W;
	localparam int GRP_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  key_length;
		logic [15:0] key_id_0;
		logic [15:0] key_id_1;
		logic [15:0] key_id_2;
		logic [15:0] key_id_3;
		logic [15:0] face_low_index;
		logic [15:0] face_high_index;
	} face_item_t;

	typedef struct packed {
		logic [5:0]  group_number;
		logic        opened_new;
		logic        table_full;
		logic [15:0] group_low;
		logic [15:0] group_high;
		logic [15:0] group_faces;
	} result_item_t;

	// One key memory entry: stored length and packed IDs.
	typedef struct packed {
		logic [2:0]       len;
		logic [KEY_W-1:0] ids;
	} key_rec_t;

	// One range memory entry: running bounds and face count.
	typedef struct packed {
		logic [15:0] low;
		logic [15:0] high;
		logic [15:0] count;
	} range_rec_t;

	typedef struct packed {
		logic             en;
		logic [GRP_W-1:0] idx;
		key_rec_t         data;
	} key_wr_t;

	typedef struct packed {
		logic             en;
		logic [GRP_W-1:0] idx;
		range_rec_t       data;
	} range_wr_t;

endpackage

`default_nettype wire

// ===== hdl/face_group_by_key_range_core.sv =====
// Top level of the face grouping block: scan control, update logic and result register.
// Usage:
// Faces enter on the face channel (face_valid, face_ready, face) and results leave
// on the result channel (result_valid, result_ready, result), one result per face.
// The block handles one face at a time. After a face is accepted, the group table
// is scanned in order, one stored group per cycle, through the key and range
// memories, whose reads are registered. The first group with the same length and
// IDs is the match; its bounds are widened, its count goes up (saturating) and the
// range entry is written back. With no match a new group is written at the next
// free number, or the face is dropped with table_full when all groups are in use.
// The block returns to idle as the result moves to the output register, and only
// then takes the next face; it never takes a new face before the last one's result
// has reached the output register.
// The output register holds a result until it is taken, so a stalled receiver
// holds back only the following face, which waits in its response state.
// Reset empties the table (no groups in use) and clears the result valid flag;
// the memories themselves need no clearing, since only opened groups are read.
`timescale 1ns / 1ps
`default_nettype none

module face_group_by_key_range_core import fgkr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         face_valid,
	output logic         face_ready,
	input  face_item_t   face,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rd_addr_q;
	logic [CNT_W-1:0] in_use_q;
	logic             chk_valid_s1;
	logic [GRP_W-1:0] chk_addr_s1;
	key_rec_t         key_q;
	logic [15:0]      low_q;
	logic [15:0]      high_q;
	result_item_t     res_q;
	result_item_t     out_q;
	logic             out_valid_q;

	key_rec_t     face_key;
	logic [15:0]  face_ids [ID_FIELDS];
	logic         issue;
	logic         hit;
	logic         miss_done;
	logic         full;
	key_rec_t     rd_key;
	range_rec_t   rd_range;
	range_rec_t   upd_range;
	key_wr_t      key_wr;
	range_wr_t    range_wr;
	result_item_t scan_res;

	// Pack the IDs that take part in the key; positions past the length are zero.
	always_comb begin
		face_ids[0] = face.key_id_0;
		face_ids[1] = face.key_id_1;
		face_ids[2] = face.key_id_2;
		face_ids[3] = face.key_id_3;
		face_key.len = face.key_length;
		face_key.ids = '0;
		for (int k = 0; k < ID_FIELDS; k++) begin
			if ((k < MAX_IDS) && (32'(face.key_length) > k)) begin
				face_key.ids[k*ID_W +: ID_W] = face_ids[k];
			end
		end
	end

	assign face_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// A read is issued for every opened group until the scan ends.
	assign issue     = (state_q == ST_SCAN) && (rd_addr_q < in_use_q);
	assign hit       = (state_q == ST_SCAN) && chk_valid_s1 && (rd_key == key_q);
	assign miss_done = (state_q == ST_SCAN) && !issue && !chk_valid_s1;
	assign full      = (in_use_q == CNT_W'(MAX_GROUPS));

	fgkr_group_store u_store (
		.clk      (clk),
		.rd_en    (issue),
		.rd_idx   (rd_addr_q[GRP_W-1:0]),
		.key_wr   (key_wr),
		.range_wr (range_wr),
		.rd_key   (rd_key),
		.rd_range (rd_range)
	);

	// Read-modify-write of the matched entry, or the new entry on a miss.
	always_comb begin
		upd_range.low   = (low_q < rd_range.low) ? low_q : rd_range.low;
		upd_range.high  = (high_q > rd_range.high) ? high_q : rd_range.high;
		upd_range.count = (rd_range.count == COUNT_MAX) ? rd_range.count
		                                                : rd_range.count + 16'd1;

		key_wr.en     = 1'b0;
		key_wr.idx    = in_use_q[GRP_W-1:0];
		key_wr.data   = key_q;
		range_wr.en   = 1'b0;
		range_wr.idx  = in_use_q[GRP_W-1:0];
		range_wr.data = '{low: low_q, high: high_q, count: 16'd1};
		scan_res      = '0;

		if (hit) begin
			range_wr.en           = 1'b1;
			range_wr.idx          = chk_addr_s1;
			range_wr.data         = upd_range;
			scan_res.group_number = 6'(chk_addr_s1);
			scan_res.group_low    = upd_range.low;
			scan_res.group_high   = upd_range.high;
			scan_res.group_faces  = upd_range.count;
		end else if (miss_done && full) begin
			scan_res.table_full = 1'b1;
		end else if (miss_done) begin
			key_wr.en             = 1'b1;
			range_wr.en           = 1'b1;
			scan_res.group_number = 6'(in_use_q);
			scan_res.opened_new   = 1'b1;
			scan_res.group_low    = low_q;
			scan_res.group_high   = high_q;
			scan_res.group_faces  = 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rd_addr_q    <= '0;
			in_use_q     <= '0;
			chk_valid_s1 <= 1'b0;
			chk_addr_s1  <= '0;
			key_q        <= '0;
			low_q        <= '0;
			high_q       <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// A read in flight is dropped once the scan has found its match.
			chk_valid_s1 <= issue && !hit;
			chk_addr_s1  <= rd_addr_q[GRP_W-1:0];

			// Move the result out once the output register is free.
			if ((state_q == ST_RESP) && (!out_valid_q || result_ready)) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (face_valid) begin
						key_q     <= face_key;
						low_q     <= face.face_low_index;
						high_q    <= face.face_high_index;
						rd_addr_q <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_addr_q <= rd_addr_q + CNT_W'(1);
					end
					if (hit || miss_done) begin
						res_q   <= scan_res;
						state_q <= ST_RESP;
						if (!hit && !full) begin
							in_use_q <= in_use_q + CNT_W'(1);
						end
					end
				end
				ST_RESP: begin
					if (!out_valid_q || result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fgkr_group_store.sv =====
// Group table storage: key memory and range memory, with registered reads.
`timescale 1ns / 1ps
`default_nettype none

module fgkr_group_store import fgkr_pkg::*; (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [GRP_W-1:0] rd_idx,
	input  key_wr_t          key_wr,
	input  range_wr_t        range_wr,
	output key_rec_t         rd_key,
	output range_rec_t       rd_range
);

	key_rec_t   key_mem   [MAX_GROUPS];
	range_rec_t range_mem [MAX_GROUPS];

	always_ff @(posedge clk) begin
		if (key_wr.en) begin
			key_mem[key_wr.idx] <= key_wr.data;
		end
		if (rd_en) begin
			rd_key <= key_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (range_wr.en) begin
			range_mem[range_wr.idx] <= range_wr.data;
		end
		if (rd_en) begin
			rd_range <= range_mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// ===== sim/face_group_by_key_range_core_test.sv =====
// Self-checking testbench for the face grouping block, predicting each result item.
`timescale 1ns / 1ps

module face_group_by_key_range_core_test;
	import fgkr_pkg::*;

	// This margin covers any tail of work after the last expected result.
	localparam int DRAIN_CYCLES = MAX_GROUPS + 16;
	// About seven hundred faces are sent in all, some runs with both sides idling;
	// this limit is several times the slowest correct run.
	localparam int CYCLE_LIMIT = 500_000;
	localparam int KEY_POOL = 40;
	localparam int SHOWN_MISMATCHES = 10;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         face_valid = 1'b0;
	logic         face_ready;
	face_item_t   face = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result;

	// Mirror of the group table, updated as each face is sent.
	logic [KEY_W-1:0] grp_key [MAX_GROUPS];
	logic [2:0]       grp_len [MAX_GROUPS];
	logic [15:0]      grp_low [MAX_GROUPS];
	logic [15:0]      grp_high [MAX_GROUPS];
	logic [15:0]      grp_count [MAX_GROUPS];
	int               grp_used = 0;

	result_item_t pending_results [$];
	result_item_t oldest_expected;
	face_item_t   key_pool [KEY_POOL];
	bit           key_pool_filled = 1'b0;
	int           sender_idle_pct = 0;
	int           receiver_idle_pct = 0;
	int           mismatch_count = 0;
	int           cycle_count = 0;

	face_group_by_key_range_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.face_valid(face_valid),
		.face_ready(face_ready),
		.face(face),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Only the positions below the effective length take part in the key.
	function automatic logic [KEY_W-1:0] key_of(input face_item_t f);
		logic [ID_W-1:0]  ids [ID_FIELDS];
		logic [KEY_W-1:0] k;
		int               n;
		ids[0] = f.key_id_0;
		ids[1] = f.key_id_1;
		ids[2] = f.key_id_2;
		ids[3] = f.key_id_3;
		n = f.key_length;
		if (n > MAX_IDS)
			n = MAX_IDS;
		if (n > ID_FIELDS)
			n = ID_FIELDS;
		k = '0;
		for (int i = 0; i < n; i++)
			k[i*ID_W +: ID_W] = ids[i];
		return k;
	endfunction

	// Joins the first matching group, opens a new one, or drops the face when full.
	function automatic result_item_t group_face(input face_item_t f);
		logic [KEY_W-1:0] k;
		result_item_t     r;
		k = key_of(f);
		r = '0;
		for (int g = 0; g < grp_used && g < MAX_GROUPS; g++) begin
			if (grp_len[g] == f.key_length && grp_key[g] == k) begin
				if (f.face_low_index < grp_low[g])
					grp_low[g] = f.face_low_index;
				if (f.face_high_index > grp_high[g])
					grp_high[g] = f.face_high_index;
				if (grp_count[g] != COUNT_MAX)
					grp_count[g] = grp_count[g] + 16'd1;
				r.group_number = 6'(g);
				r.group_low = grp_low[g];
				r.group_high = grp_high[g];
				r.group_faces = grp_count[g];
				return r;
			end
		end
		if (grp_used >= MAX_GROUPS) begin
			r.table_full = 1'b1;
			return r;
		end
		grp_key[grp_used] = k;
		grp_len[grp_used] = f.key_length;
		grp_low[grp_used] = f.face_low_index;
		grp_high[grp_used] = f.face_high_index;
		grp_count[grp_used] = 16'd1;
		r.group_number = 6'(grp_used);
		r.opened_new = 1'b1;
		r.group_low = f.face_low_index;
		r.group_high = f.face_high_index;
		r.group_faces = 16'd1;
		grp_used++;
		return r;
	endfunction

	function automatic face_item_t make_face(input logic [2:0] len,
			input logic [15:0] i0, i1, i2, i3, lo, hi);
		face_item_t f;
		f.key_length = len;
		f.key_id_0 = i0;
		f.key_id_1 = i1;
		f.key_id_2 = i2;
		f.key_id_3 = i3;
		f.face_low_index = lo;
		f.face_high_index = hi;
		return f;
	endfunction

	// Mostly ordered ranges, some at the extremes, some left reversed.
	function automatic face_item_t with_random_range(input face_item_t f);
		logic [15:0] lo;
		logic [15:0] hi;
		lo = 16'($urandom);
		hi = 16'($urandom);
		case ($urandom_range(9))
			0: begin
				lo = '0;
				hi = '1;
			end
			1: ;
			default: begin
				if (lo > hi) begin
					f.face_low_index = hi;
					hi = lo;
					lo = f.face_low_index;
				end
			end
		endcase
		f.face_low_index = lo;
		f.face_high_index = hi;
		return f;
	endfunction

	function automatic face_item_t random_face();
		return with_random_range(make_face(3'($urandom_range(7)), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), '0, '0));
	endfunction

	function automatic face_item_t face_for_group(input int g);
		face_item_t f;
		f = random_face();
		f.key_length = grp_len[g];
		f.key_id_0 = grp_key[g][15:0];
		f.key_id_1 = grp_key[g][31:16];
		f.key_id_2 = grp_key[g][47:32];
		f.key_id_3 = grp_key[g][63:48];
		return f;
	endfunction

	// Valid is only lowered when the sender idles, so it never drops between items.
	task automatic send_face(input face_item_t item);
		result_item_t want;
		while ($urandom_range(99) < sender_idle_pct) begin
			face_valid <= 1'b0;
			@(posedge clk);
		end
		want = group_face(item);
		pending_results = {pending_results, want};
		face <= item;
		face_valid <= 1'b1;
		@(posedge clk);
		while (!face_ready)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input result_item_t want,
			input result_item_t got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES)
			$display("%0t %s: expected grp=%0d new=%b full=%b low=%h high=%h faces=%0d, got grp=%0d new=%b full=%b low=%h high=%h faces=%0d",
				$time, what, want.group_number, want.opened_new, want.table_full,
				want.group_low, want.group_high, want.group_faces, got.group_number,
				got.opened_new, got.table_full, got.group_low, got.group_high,
				got.group_faces);
	endtask

	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= receiver_idle_pct);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected", '0, result);
			end else begin
				oldest_expected = pending_results.pop_front();
				if (result.group_number !== oldest_expected.group_number ||
						result.opened_new !== oldest_expected.opened_new ||
						result.table_full !== oldest_expected.table_full ||
						result.group_low !== oldest_expected.group_low ||
						result.group_high !== oldest_expected.group_high ||
						result.group_faces !== oldest_expected.group_faces)
					report_mismatch("result differs", oldest_expected, result);
			end
		end
	end

	// Zero-length keys, oversized lengths, reversed ranges and bit extremes.
	task automatic test_directed_cases();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		send_face(make_face(3'd0, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h0000, 16'hFFFF));
		// A zero-length key matches group 0 whatever its IDs hold.
		send_face(make_face(3'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'd100, 16'd200));
		send_face(make_face(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_face(make_face(3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		send_face(make_face(3'd4, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA));
		send_face(make_face(3'd1, 16'h1234, 16'h0BAD, 16'h0BAD, 16'h0BAD, 16'd300, 16'd400));
		// IDs past the length are ignored, so this joins the previous group.
		send_face(make_face(3'd1, 16'h1234, 16'hBEEF, 16'hCAFE, 16'hF00D, 16'd250, 16'd350));
		send_face(make_face(3'd2, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'd1, 16'd2));
		// Lengths above four keep their full value but compare only four IDs.
		send_face(make_face(3'd5, 16'hA001, 16'hA002, 16'hA003, 16'hA004, 16'd10, 16'd20));
		send_face(make_face(3'd4, 16'hA001, 16'hA002, 16'hA003, 16'hA004, 16'd10, 16'd20));
		send_face(make_face(3'd7, 16'hA001, 16'hA002, 16'hA003, 16'hA004, 16'd10, 16'd20));
		send_face(make_face(3'd6, 16'hA001, 16'hA002, 16'hA003, 16'hA004, 16'd10, 16'd20));
		send_face(make_face(3'd5, 16'hA001, 16'hA002, 16'hA003, 16'hA004, 16'd5, 16'd30));
		send_face(make_face(3'd7, 16'hA001, 16'hA002, 16'hA003, 16'hA004, 16'd15, 16'd15));
		// Reversed ranges are stored as given and then widened on each side.
		send_face(make_face(3'd3, 16'h0777, 16'h0888, 16'h0999, 16'h0000, 16'd500, 16'd20));
		send_face(make_face(3'd3, 16'h0777, 16'h0888, 16'h0999, 16'h1234, 16'd600, 16'd10));
		send_face(make_face(3'd3, 16'h0777, 16'h0888, 16'h0999, 16'h5678, 16'd5, 16'd1000));
		send_face(make_face(3'd3, 16'h0777, 16'h0888, 16'h0998, 16'h0000, 16'd0, 16'hFFFF));
		send_face(make_face(3'd2, 16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000));
	endtask

	// Mostly repeats of pooled keys, with fresh keys and near misses mixed in.
	task automatic test_random_mix(input int count, input int send_idle, input int take_idle);
		face_item_t f;
		int         pick;
		sender_idle_pct = send_idle;
		receiver_idle_pct = take_idle;
		if (!key_pool_filled) begin
			foreach (key_pool[i])
				key_pool[i] = random_face();
			key_pool_filled = 1'b1;
		end
		repeat (count) begin
			pick = $urandom_range(99);
			f = key_pool[$urandom_range(KEY_POOL - 1)];
			if (pick >= 75 && pick < 88) begin
				f = random_face();
			end else if (pick >= 88) begin
				case ($urandom_range(4))
					0: f.key_length = f.key_length ^ 3'(1 << $urandom_range(2));
					1: f.key_id_0[$urandom_range(15)] = ~f.key_id_0[$urandom_range(15)];
					2: f.key_id_1[$urandom_range(15)] = ~f.key_id_1[$urandom_range(15)];
					3: f.key_id_2 = 16'($urandom);
					default: f.key_id_3 = 16'($urandom);
				endcase
			end
			send_face(with_random_range(f));
		end
	endtask

	// Fill every group, then show that new keys are dropped while old ones still join.
	task automatic test_table_full();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		while (grp_used < MAX_GROUPS)
			send_face(random_face());
		repeat (8) begin
			send_face(random_face());
			send_face(face_for_group($urandom_range(MAX_GROUPS - 1)));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_random_mix(200, 33, 61);
		test_random_mix(200, 61, 33);
		test_random_mix(200, 0, 0);
		test_table_full();
		face_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/fgkr_pkg.sv
hdl/fgkr_group_store.sv
hdl/face_group_by_key_range_core.sv
sim/face_group_by_key_range_core_test.sv
